@@ rtl/bnts_pkg.sv @@
// ----------------------------------------------------------------------------
// bnts_pkg: shared types and constants of the buzzer note tone sequencer
// Request and response structs, command codes, register indexes, reset
// values, sequencer states and divider interface types.
// ----------------------------------------------------------------------------
package bnts_pkg;

   // field widths
   localparam int CMD_W      = 2;
   localparam int PERIOD_W   = 16;
   localparam int DURATION_W = 24;
   localparam int PITCH_W    = 8;
   localparam int MAXPLAY_W  = 26;
   localparam int ELAPSED_W  = 25;
   localparam int TOTAL_W    = 27;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 26;

   // shared divider geometry
   localparam int DIVIDEND_W = DURATION_W;
   localparam int DIVISOR_W  = 8;

   // defaults
   localparam int DUTY_DIVISOR_DEF = 10;
   localparam int PERIOD_MAX       = 65535;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_DIVISOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PLAY_US   = 1'b1;

   // register reset values
   localparam logic [PITCH_W-1:0]   PITCH_DIVISOR_RST = 8'd2;
   localparam logic [MAXPLAY_W-1:0] MAX_PLAY_US_RST   = 26'd30000000;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [PERIOD_W-1:0]   note_period_us;
      logic [DURATION_W-1:0] note_duration_us;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic stopped;
      logic note_accepted;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_CHK,
      ST_DIV_PER,
      ST_DIV_AUX,
      ST_LEN_CHK,
      ST_FINISH,
      ST_CHECK_MAX,
      ST_RESP
   } state_type;

endpackage

@@ rtl/bnts_div.sv @@
// ----------------------------------------------------------------------------
// bnts_div: shared serial divider
// Restoring unsigned division, one quotient bit per cycle. Done pulses for
// one cycle with the quotient valid from then until the next start.
// ----------------------------------------------------------------------------
module bnts_div
   import bnts_pkg::*;
#(
   parameter int DIVD_W = DIVIDEND_W,
   parameter int DIVS_W = DIVISOR_W
) (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIVS_W'(trial - {1'b0, dvs_ff}) : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/buzzer_note_tone_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// buzzer_note_tone_sequencer_top: square-wave buzzer note sequencer
// Plays notes and rests on microsecond ticks; one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: a one-microsecond tick, a note load or a
//   restart. A request is taken when req_valid is high and req_stall low.
//   rsp_* returns exactly one response per request: pin level, busy,
//   stopped and whether a load was taken.
//   csr_* writes pitch_divisor (index 0) or max_play_us (index 1); write
//   only while no request is in flight.
// Flow (from acceptance to the registered response):
//   a tick passes ST_TICK_CHK, ST_FINISH, ST_CHECK_MAX only as needed; a
//   refused load, a restart or an unused code goes straight to ST_RESP.
//   An accepted load runs the shared 24-step serial divider twice (period
//   / pitch, then scaled period / duty divisor or duration / pitch).
//   req_stall is high from acceptance until the response is registered.
// Reset:
//   Synchronous, active high. Registers return to their default values,
//   playback state and total are cleared, no response is pending.
// Receiver stall:
//   The response register holds while rsp_stall is high; the next request
//   can be accepted meanwhile but its response waits for the register.
// ----------------------------------------------------------------------------
module buzzer_note_tone_sequencer_top
   import bnts_pkg::*;
#(
   parameter int DUTY_DIVISOR = DUTY_DIVISOR_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // high phase width follows from the largest scaled period / duty divisor
   localparam int HIGH_W = $clog2(PERIOD_MAX / DUTY_DIVISOR + 1);

   // registers
   logic [PITCH_W-1:0]   pitch_ff;
   logic [MAXPLAY_W-1:0] max_play_ff;

   // sequencer and playback state
   state_type             state_ff, state_in;
   logic [PERIOD_W-1:0]   scaled_ff, scaled_in;
   logic [HIGH_W-1:0]     high_ff, high_in;
   logic [PERIOD_W-1:0]   phase_ff, phase_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [DURATION_W-1:0] length_ff, length_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  rest_ff, rest_in;
   logic                  playing_ff, playing_in;
   logic                  halted_ff, halted_in;
   logic                  acc_ff, acc_in;
   logic [DURATION_W-1:0] dur_ff, dur_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                 req_take;
   logic [DIVISOR_W-1:0] div_eff;
   logic [PERIOD_W:0]    phase_inc;
   logic [TOTAL_W:0]     total_sum;
   logic [ELAPSED_W-1:0] addend;

   bnts_div #(
      .DIVD_W (DIVIDEND_W),
      .DIVS_W (DIVISOR_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // a zero divisor acts as one
   assign div_eff   = (pitch_ff == '0) ? DIVISOR_W'(1) : DIVISOR_W'(pitch_ff);
   assign phase_inc = {1'b0, phase_ff} + 1'b1;

   // saturating total: rest adds its length, tone adds its elapsed time
   assign addend    = rest_ff ? {1'b0, length_ff} : elapsed_ff;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(addend);

   always_comb begin
      state_in     = state_ff;
      scaled_in    = scaled_ff;
      high_in      = high_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      length_in    = length_ff;
      total_in     = total_ff;
      rest_in      = rest_ff;
      playing_in   = playing_ff;
      halted_in    = halted_ff;
      acc_in       = acc_ff;
      dur_in       = dur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               acc_in   = 1'b0;
               dur_in   = req_data.note_duration_us;
               state_in = ST_RESP;
               case (req_data.cmd)
                  CMD_TICK: begin
                     if (playing_ff && !halted_ff) begin
                        if (rest_ff) begin
                           elapsed_in = elapsed_ff + 1'b1;
                           state_in   = ST_TICK_CHK;
                        end else if (phase_inc >= {1'b0, scaled_ff}) begin
                           phase_in   = '0;
                           elapsed_in = elapsed_ff + ELAPSED_W'(scaled_ff);
                           state_in   = ST_TICK_CHK;
                        end else begin
                           phase_in = phase_inc[PERIOD_W-1:0];
                        end
                     end
                  end
                  CMD_LOAD: begin
                     if (!playing_ff && !halted_ff) begin
                        acc_in           = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVIDEND_W'(req_data.note_period_us);
                        div_req.divisor  = div_eff;
                        state_in         = ST_DIV_PER;
                     end
                  end
                  CMD_RESTART: begin
                     scaled_in  = '0;
                     high_in    = '0;
                     phase_in   = '0;
                     elapsed_in = '0;
                     length_in  = '0;
                     total_in   = '0;
                     rest_in    = 1'b0;
                     playing_in = 1'b0;
                     halted_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK_CHK: begin
            state_in = (elapsed_ff >= {1'b0, length_ff}) ? ST_FINISH : ST_RESP;
         end
         ST_DIV_PER: begin
            if (div_rsp.done) begin
               scaled_in        = div_rsp.quotient[PERIOD_W-1:0];
               phase_in         = '0;
               elapsed_in       = '0;
               div_req.start    = 1'b1;
               state_in         = ST_DIV_AUX;
               if (div_rsp.quotient == '0) begin
                  // scaled period of zero: play as rest
                  rest_in          = 1'b1;
                  high_in          = '0;
                  div_req.dividend = dur_ff;
                  div_req.divisor  = div_eff;
               end else begin
                  rest_in          = 1'b0;
                  length_in        = dur_ff;
                  div_req.dividend = div_rsp.quotient;
                  div_req.divisor  = DIVISOR_W'(DUTY_DIVISOR);
               end
            end
         end
         ST_DIV_AUX: begin
            if (div_rsp.done) begin
               if (rest_ff) begin
                  length_in = div_rsp.quotient;
               end else begin
                  high_in = HIGH_W'(div_rsp.quotient);
               end
               playing_in = 1'b1;
               state_in   = ST_LEN_CHK;
            end
         end
         ST_LEN_CHK: begin
            // zero-length note finishes at load
            state_in = (length_ff == '0) ? ST_FINISH : ST_RESP;
         end
         ST_FINISH: begin
            playing_in = 1'b0;
            phase_in   = '0;
            total_in   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            state_in   = rest_ff ? ST_RESP : ST_CHECK_MAX;
         end
         ST_CHECK_MAX: begin
            if (total_ff > TOTAL_W'(max_play_ff)) begin
               halted_in = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pin_level     = playing_ff && !rest_ff &&
                                           (phase_ff < PERIOD_W'(high_ff));
               rsp_data_in.busy_res      = playing_ff;
               rsp_data_in.stopped       = halted_ff;
               rsp_data_in.note_accepted = acc_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      dur_ff      <= dur_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         scaled_ff    <= '0;
         high_ff      <= '0;
         phase_ff     <= '0;
         elapsed_ff   <= '0;
         length_ff    <= '0;
         total_ff     <= '0;
         rest_ff      <= 1'b0;
         playing_ff   <= 1'b0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scaled_ff    <= scaled_in;
         high_ff      <= high_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         length_ff    <= length_in;
         total_ff     <= total_in;
         rest_ff      <= rest_in;
         playing_ff   <= playing_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff    <= PITCH_DIVISOR_RST;
         max_play_ff <= MAX_PLAY_US_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PITCH_DIVISOR: pitch_ff    <= csr_wdata[PITCH_W-1:0];
            CSR_MAX_PLAY_US:   max_play_ff <= csr_wdata[MAXPLAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the buzzer note tone sequencer
// A directed table (idle ticks, rests, zero-length notes, refused loads,
// stop on the play limit, restart, divisor extremes) is followed by
// random phases of note sequences with random register settings. Each
// response is checked against a cycle-free model or a typed table value.
// ----------------------------------------------------------------------------
module tb_top;
   import bnts_pkg::*;

   localparam int          LIMIT_CYCLES = 600000;
   localparam int          DUTY         = DUTY_DIVISOR_DEF;
   localparam int          RAND_ITEMS   = 950;
   localparam int          PHASE_ITEMS  = 100;
   localparam int          SETTLE       = 8;
   localparam logic [26:0] TOTAL_SAT    = 27'h7FFFFFF;
   // command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   buzzer_note_tone_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Sequencer model: register copies and playback state
   // ------------------------------------------------------------------------
   logic [PITCH_W-1:0]   cfg_divisor;
   logic [MAXPLAY_W-1:0] cfg_limit;
   logic [15:0]          tone_period;   // period after pitch division
   logic [12:0]          tone_high;     // ticks the pin stays high per cycle
   logic [15:0]          phase_cnt;
   logic [ELAPSED_W-1:0] note_time;
   logic [23:0]          note_len;
   logic [TOTAL_W-1:0]   play_total;
   logic                 in_rest;
   logic                 sounding;
   logic                 locked_out;    // play limit exceeded

   rsp_type outputs_due [$];            // responses still owed by the block
   int      mismatches = 0;
   int      effective_sent = 0;         // requests that change the state
   bit      snd_idle = 1'b1;
   bit      rcv_idle = 1'b1;
   int      hold_cycles = 0;            // one long receiver hold-off, on request

   function automatic void silence_all();
      tone_period = '0;
      tone_high   = '0;
      phase_cnt   = '0;
      note_time   = '0;
      note_len    = '0;
      play_total  = '0;
      in_rest     = 1'b0;
      sounding    = 1'b0;
      locked_out  = 1'b0;
   endfunction

   // end of a note or rest: accumulate the total (saturating); only a tone
   // is checked against the play limit
   function automatic void close_note();
      logic [27:0] sum;
      sounding  = 1'b0;
      phase_cnt = '0;
      sum = {1'b0, play_total} + (in_rest ? 28'(note_len) : 28'(note_time));
      play_total = (sum > 28'(TOTAL_SAT)) ? TOTAL_SAT : sum[26:0];
      if (!in_rest && play_total > 27'(cfg_limit))
         locked_out = 1'b1;
   endfunction

   function automatic rsp_type buzzer_outputs(req_type r);
      rsp_type      o;
      logic [7:0]   dv;
      logic         took;
      took = 1'b0;
      dv   = (cfg_divisor == '0) ? 8'd1 : cfg_divisor;
      case (r.cmd)
         CMD_TICK: begin
            if (sounding && !locked_out) begin
               if (in_rest) begin
                  note_time = note_time + 25'd1;
                  if (note_time >= 25'(note_len))
                     close_note();
               end else begin
                  phase_cnt = phase_cnt + 16'd1;
                  if (phase_cnt >= tone_period) begin
                     phase_cnt = '0;
                     note_time = note_time + 25'(tone_period);
                     if (note_time >= 25'(note_len))
                        close_note();
                  end
               end
            end
         end
         CMD_LOAD: begin
            if (!sounding && !locked_out) begin
               took        = 1'b1;
               tone_period = r.note_period_us / 16'(dv);
               phase_cnt   = '0;
               note_time   = '0;
               if (tone_period == '0) begin
                  // too short to sound: played as a rest
                  in_rest   = 1'b1;
                  tone_high = '0;
                  note_len  = r.note_duration_us / 24'(dv);
               end else begin
                  in_rest   = 1'b0;
                  tone_high = 13'(tone_period / 16'(DUTY));
                  note_len  = r.note_duration_us;
               end
               sounding = 1'b1;
               if (note_len == '0)
                  close_note();
            end
         end
         CMD_RESTART: silence_all();
         default: ;
      endcase
      o.pin_level     = sounding && !in_rest && (phase_cnt < 16'(tone_high));
      o.busy_res      = sounding;
      o.stopped       = locked_out;
      o.note_accepted = took;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: random gap when snd_idle is set, then hold the request until taken.
   // The model runs when the request is issued, so the stimulus below can
   // steer on its state.
   // ------------------------------------------------------------------------
   task automatic send_request(req_type r, bit typed, rsp_type want);
      int      gap;
      bit      eff;
      rsp_type modeled;
      gap = snd_idle ? $urandom_range(0, 11) : 0;
      eff = (r.cmd == CMD_RESTART) ||
            (r.cmd == CMD_TICK && sounding && !locked_out) ||
            (r.cmd == CMD_LOAD && !sounding && !locked_out);
      modeled = buzzer_outputs(r);
      if (eff)
         effective_sent++;
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      outputs_due.push_back(typed ? want : modeled);
      do @(posedge clock); while (req_stall);
   endtask

   function automatic req_type make_req(logic [CMD_W-1:0] c);
      req_type r;
      r.cmd              = c;
      r.note_period_us   = 16'($urandom);
      r.note_duration_us = 24'($urandom);
      return r;
   endfunction

   // drop valid and wait until the block owes nothing
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      wait (outputs_due.size() == 0);
   endtask

   // register write, only with the block idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
      if (idx == CSR_PITCH_DIVISOR)
         cfg_divisor = val[PITCH_W-1:0];
      else
         cfg_limit = val[MAXPLAY_W-1:0];
   endtask

   // one well-formed note: optional restart, load, then ticks to its end
   // with the odd stray request mixed in
   task automatic play_one_note();
      req_type r;
      int      dv;
      int      s;
      int      n;
      int      pick;
      dv = (cfg_divisor == '0) ? 1 : int'(cfg_divisor);
      if ((sounding || locked_out) && $urandom_range(0, 9) < 8)
         send_request(make_req(CMD_RESTART), 1'b0, '0);
      r    = make_req(CMD_LOAD);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         s = $urandom_range(1, 40);
         r.note_period_us   = 16'(s * dv + $urandom_range(0, dv - 1));
         r.note_duration_us = 24'($urandom_range(0, 120));
      end else if (pick < 9) begin
         r.note_period_us   = 16'($urandom_range(0, dv - 1));
         r.note_duration_us = 24'($urandom_range(0, 60 * dv));
      end else begin
         r.note_duration_us = '0;
      end
      send_request(r, 1'b0, '0);
      n = 0;
      while (sounding && n < 300) begin
         pick = $urandom_range(0, 999);
         if (pick < 10)
            send_request(make_req(CMD_UNUSED), 1'b0, '0);
         else if (pick < 20)
            send_request(make_req(CMD_LOAD), 1'b0, '0);
         else if (pick < 23)
            send_request(make_req(CMD_RESTART), 1'b0, '0);
         else
            send_request(make_req(CMD_TICK), 1'b0, '0);
         n++;
      end
      repeat ($urandom_range(0, 2))
         send_request(make_req(CMD_TICK), 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Directed table. want = {pin, busy, stopped, accepted}, used where typed
   // is set; other rows are checked against the model. Rows of kind ROW_CSR
   // write register 'code' with 'value'.
   // ------------------------------------------------------------------------
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e   kind;
      logic [1:0]  code;
      logic [15:0] period;
      logic [25:0] value;
      logic [7:0]  reps;
      logic        typed;
      logic [3:0]  want;
   } step_row_t;

   localparam logic [1:0] IDX_PITCH = {1'b0, CSR_PITCH_DIVISOR};
   localparam logic [1:0] IDX_LIMIT = {1'b0, CSR_MAX_PLAY_US};

   step_row_t script [0:27] = '{
      // idle tick and the unused code change nothing
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd1,  1'b1, 4'b0000},
      '{ROW_REQ, CMD_UNUSED,  16'hFFFF,  26'hFFFFFF,   8'd1,  1'b1, 4'b0000},
      // zero-length rest completes at load
      '{ROW_REQ, CMD_LOAD,    16'd0,     26'd0,        8'd1,  1'b1, 4'b0001},
      // period scales to zero: rest of 5/2 ticks
      '{ROW_REQ, CMD_LOAD,    16'd1,     26'd5,        8'd1,  1'b1, 4'b0101},
      // load while busy is refused
      '{ROW_REQ, CMD_LOAD,    16'd100,   26'd9,        8'd1,  1'b1, 4'b0100},
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd2,  1'b0, 4'b0000},
      // zero-duration tone
      '{ROW_REQ, CMD_LOAD,    16'd40,    26'd0,        8'd1,  1'b1, 4'b0001},
      // longest note, pin starts high
      '{ROW_REQ, CMD_LOAD,    16'hFFFF,  26'hFFFFFF,   8'd1,  1'b1, 4'b1101},
      '{ROW_REQ, CMD_TICK,    16'hFFFF,  26'hFFFFFF,   8'd1,  1'b1, 4'b1100},
      '{ROW_REQ, CMD_RESTART, 16'd0,     26'd0,        8'd1,  1'b1, 4'b0000},
      // one full cycle of a 10-tick tone
      '{ROW_REQ, CMD_LOAD,    16'd20,    26'd10,       8'd1,  1'b1, 4'b1101},
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd10, 1'b0, 4'b0000},
      // zero play limit: next tone stops playback
      '{ROW_CSR, IDX_LIMIT,   16'd0,     26'd0,        8'd1,  1'b0, 4'b0000},
      '{ROW_REQ, CMD_LOAD,    16'd4,     26'd1,        8'd1,  1'b1, 4'b0101},
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd2,  1'b0, 4'b0000},
      // stopped: loads and ticks are ignored
      '{ROW_REQ, CMD_LOAD,    16'd20,    26'd10,       8'd1,  1'b1, 4'b0010},
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd1,  1'b1, 4'b0010},
      '{ROW_REQ, CMD_RESTART, 16'd0,     26'd0,        8'd1,  1'b1, 4'b0000},
      // a rest never trips the limit
      '{ROW_REQ, CMD_LOAD,    16'd0,     26'd8,        8'd1,  1'b1, 4'b0101},
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd4,  1'b0, 4'b0000},
      // divisor zero acts as one
      '{ROW_CSR, IDX_PITCH,   16'd0,     26'd0,        8'd1,  1'b0, 4'b0000},
      '{ROW_REQ, CMD_LOAD,    16'd9,     26'd3,        8'd1,  1'b1, 4'b0101},
      '{ROW_REQ, CMD_TICK,    16'd0,     26'd0,        8'd9,  1'b0, 4'b0000},
      '{ROW_REQ, CMD_RESTART, 16'd0,     26'd0,        8'd1,  1'b1, 4'b0000},
      // largest divisor and largest limit
      '{ROW_CSR, IDX_PITCH,   16'd0,     26'd255,      8'd1,  1'b0, 4'b0000},
      '{ROW_CSR, IDX_LIMIT,   16'd0,     26'h3FFFFFF,  8'd1,  1'b0, 4'b0000},
      '{ROW_REQ, CMD_LOAD,    16'hFFFF,  26'hFFFFFF,   8'd1,  1'b1, 4'b1101},
      '{ROW_REQ, CMD_RESTART, 16'd0,     26'd0,        8'd1,  1'b1, 4'b0000}
   };

   // ------------------------------------------------------------------------
   // Main stimulus
   // ------------------------------------------------------------------------
   initial begin
      req_type r;
      int      k;
      int      base;
      int      start;
      bit      paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      cfg_divisor = PITCH_DIVISOR_RST;
      cfg_limit   = MAX_PLAY_US_RST;
      silence_all();
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            write_reg(script[i].code[CSR_IDX_W-1:0], script[i].value);
         end else begin
            repeat (script[i].reps) begin
               r.cmd              = script[i].code;
               r.note_period_us   = script[i].period;
               r.note_duration_us = script[i].value[23:0];
               send_request(r, script[i].typed, rsp_type'(script[i].want));
            end
         end
      end

      // random phases, each with its own register setting and idling mix
      k    = 0;
      base = effective_sent;
      while (effective_sent - base < RAND_ITEMS) begin
         case (k % 5)
            0: write_reg(CSR_PITCH_DIVISOR, CSR_DATA_W'(1));
            1: write_reg(CSR_PITCH_DIVISOR, CSR_DATA_W'(255));
            2: write_reg(CSR_PITCH_DIVISOR, CSR_DATA_W'(2));
            default: write_reg(CSR_PITCH_DIVISOR, CSR_DATA_W'($urandom_range(1, 16)));
         endcase
         case (k % 4)
            0: write_reg(CSR_MAX_PLAY_US, 26'h3FFFFFF);
            1: write_reg(CSR_MAX_PLAY_US, CSR_DATA_W'($urandom_range(0, 400)));
            2: write_reg(CSR_MAX_PLAY_US, '0);
            default: write_reg(CSR_MAX_PLAY_US, CSR_DATA_W'($urandom_range(100, 3000)));
         endcase
         snd_idle = (k % 4 != 1);
         rcv_idle = (k % 3 != 2);
         // receiver backs off for a long stretch while requests keep coming
         if (k == 2)
            hold_cycles = 300;
         paused = 1'b0;
         start  = effective_sent;
         while (effective_sent - start < PHASE_ITEMS &&
                effective_sent - base < RAND_ITEMS) begin
            // sender stops mid-phase until every response is back
            if (k == 3 && !paused && effective_sent - start >= PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
               play_one_note();
            else
               send_request(make_req(2'($urandom_range(0, 3))), 1'b0, '0);
         end
         k++;
      end

      drain();
      repeat (4 * SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random stall per response, plus the one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int gap;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         gap = rcv_idle ? $urandom_range(0, 11) : 0;
         if (hold_cycles > 0) begin
            gap         = hold_cycles;
            hold_cycles = 0;
         end
         repeat (gap) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outputs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response pin=%b busy=%b stop=%b acc=%b",
                        rsp_data.pin_level, rsp_data.busy_res,
                        rsp_data.stopped, rsp_data.note_accepted);
         end else begin
            want = outputs_due.pop_front();
            if (rsp_data.pin_level     !== want.pin_level ||
                rsp_data.busy_res      !== want.busy_res  ||
                rsp_data.stopped       !== want.stopped   ||
                rsp_data.note_accepted !== want.note_accepted) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected pin=%b busy=%b stop=%b acc=%b, got %b %b %b %b",
                           want.pin_level, want.busy_res, want.stopped,
                           want.note_accepted, rsp_data.pin_level,
                           rsp_data.busy_res, rsp_data.stopped,
                           rsp_data.note_accepted);
            end
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * 4);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
rtl/bnts_pkg.sv
rtl/bnts_div.sv
rtl/buzzer_note_tone_sequencer_top.sv
test/tb_top.sv
